// ===== design/rit_pkg.sv =====
// Shared types and constants for the rotor index position tracker.
// No dependencies; the other design files import this package.
`default_nettype none

package rit_pkg;

  localparam int WidthBits = 8;
  localparam int CountBits = 8;
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits = 8;

  localparam logic [CfgDataBits-1:0] PprReset = 8'd24;
  localparam logic [CfgDataBits-1:0] ThreshReset = 8'd16;

  typedef logic [WidthBits-1:0] width_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_PPR    = 2'd0,
    REG_THRESH = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [CfgDataBits-1:0] pulses_per_rotation;
    logic [CfgDataBits-1:0] mark_margin;
  } cfg_t;

  typedef struct packed {
    count_t position;
    logic   locked;
  } result_t;

endpackage

`default_nettype wire

// ===== design/rit_cfg_regs.sv =====
// Configuration register file: pulses per rotation and index threshold.
// Depends on rit_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module rit_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [rit_pkg::CfgIndexBits-1:0] wr_index,
  input  wire logic [rit_pkg::CfgDataBits-1:0]  wr_data,
  output rit_pkg::cfg_t                      cfg
);
  import rit_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_rotation <= PprReset;
      cfg.mark_margin         <= ThreshReset;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PPR:    cfg.pulses_per_rotation <= wr_data;
        REG_THRESH: cfg.mark_margin         <= wr_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rit_tracker_core.sv =====
// Tracking state: width history, lock flag and pulse count, with the
// combinational index detect and count update. Depends on rit_pkg.
`default_nettype none

module rit_tracker_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire rit_pkg::width_t  width,
  input  wire rit_pkg::cfg_t    cfg,
  output rit_pkg::result_t      cur,
  output rit_pkg::result_t      res
);
  import rit_pkg::*;

  width_t hist [3];
  logic   sync_flag;
  count_t pulse_count;

  logic        index_hit;
  logic [8:0]  left_sum;
  logic [8:0]  right_sum;
  count_t      count_inc;
  logic        sync_next;
  count_t      count_next;
  logic        pulse;

  assign pulse = step && (width != '0);

  // Before the shift the middle entry is hist[2], its neighbours hist[1] and width
  assign left_sum  = {1'b0, hist[1]} + {1'b0, cfg.mark_margin};
  assign right_sum = {1'b0, width} + {1'b0, cfg.mark_margin};
  assign index_hit = ({1'b0, hist[2]} >= left_sum) && ({1'b0, hist[2]} >= right_sum);
  assign count_inc = pulse_count + count_t'(1);

  always_comb begin
    sync_next  = sync_flag;
    count_next = pulse_count;
    if (pulse) begin
      if (!sync_flag) begin
        if (index_hit) begin
          sync_next  = 1'b1;
          count_next = count_t'(1);
        end
      end else begin
        count_next = count_inc;
        if (count_inc > cfg.pulses_per_rotation) begin
          if (index_hit) count_next = '0;
          else           sync_next  = 1'b0;  // late index
        end else if (index_hit) begin
          sync_next = 1'b0;  // early index
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist[0]     <= '0;
      hist[1]     <= '0;
      hist[2]     <= '0;
      sync_flag   <= 1'b0;
      pulse_count <= '0;
    end else if (pulse) begin
      hist[0]     <= hist[1];
      hist[1]     <= hist[2];
      hist[2]     <= width;
      sync_flag   <= sync_next;
      pulse_count <= count_next;
    end
  end

  assign cur.position = pulse_count;
  assign cur.locked   = sync_flag;
  assign res.position = count_next;
  assign res.locked   = sync_next;

endmodule

`default_nettype wire

// ===== design/rotor_index_position_tracker.sv =====
// Top level of the rotor index position tracker: input register, tracking
// core, result register and configuration registers. Depends on rit_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, pulse_width) takes one measured pulse
//   width per word; a width of zero is a timeout and leaves the state alone.
//   Output channel (out_valid/out_ready, position, locked) returns exactly
//   one word per input word, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   register 0 (pulses per rotation) or 1 (index threshold); other indexes
//   are dropped. cfg_ready is always high. Write only while the block is idle.
// Timing:
//   An accepted word is held in the input register, which feeds the core;
//   the core's result is loaded into the result register when it advances.
//   Throughput is one word per cycle unless out_ready stalls; the core updates
//   its state in the cycle it loads the result, so words follow back to back.
// Reset (rst, synchronous): registers return to 24 and 16, history clears,
//   the block unlocks with position 0, both pipeline stages empty.
// Stall: while out_ready is low the result holds and the input register
//   keeps one more word; in_ready drops only when both stages are full.
`default_nettype none

module rotor_index_position_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rit_pkg::WidthBits-1:0]    pulse_width,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rit_pkg::CountBits-1:0]         position,
  output logic                                  locked,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rit_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [rit_pkg::CfgDataBits-1:0]  cfg_data
);
  import rit_pkg::*;

  cfg_t    cfg;
  result_t cur;
  result_t res;

  logic    in_reg_valid;
  width_t  in_reg_width;
  logic    advance;
  logic    step;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign step      = in_reg_valid && advance;
  assign in_ready  = !in_reg_valid || advance;

  rit_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rit_tracker_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .width (in_reg_width),
    .cfg   (cfg),
    .cur   (cur),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_width <= pulse_width;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      position <= res.position;
      locked   <= res.locked;
    end
  end

  // Backpressure reaches the input only when both stages are full
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_reg_valid && out_valid && !out_ready))
    else $error("in_ready low without a full, stalled pipeline");

  // A result appears only from an item held in the input register
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_reg_valid))
    else $error("result valid without a staged item");

  // A fresh lock starts counting at one
  a_lock_start: assert property (@(posedge clk) disable iff (rst)
    (step && !cur.locked && res.locked) |-> (res.position == count_t'(1)))
    else $error("lock acquired with position other than one");

  // A timeout leaves the reported state unchanged
  a_timeout_hold: assert property (@(posedge clk) disable iff (rst)
    (step && (in_reg_width == '0)) |-> (res == cur))
    else $error("timeout changed the tracking state");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the rotor index position tracker.
// Tracks the expected position and lock flag alongside the block and checks
// every result word. Depends on rit_pkg and the rotor_index_position_tracker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rit_pkg::*;

  typedef logic [CfgDataBits-1:0] cfg_data_t;

  // indexes past the register map; writes to them must be dropped
  localparam logic [CfgIndexBits-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIndexBits-1:0] RegSpareB = 2'd3;
  localparam int MaxReports = 10;
  localparam int RandomPulses = 150;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  width_t                  pulse_width = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  count_t                  position;
  logic                    locked;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;

  rotor_index_position_tracker u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pulse_width (pulse_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .locked      (locked),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected tracker state, kept in step with every word sent
  cfg_t    trk_cfg;
  width_t  trk_hist [3];
  logic    trk_locked;
  count_t  trk_count;
  result_t position_q [$];

  int n_pulses, n_timeouts, n_results, n_mismatch;
  int n_lock, n_rezero, n_early, n_late, n_wrap;
  bit tx_gaps, rx_stalls;
  int ready_hold;

  function automatic void reset_tracker();
    trk_cfg.pulses_per_rotation = PprReset;
    trk_cfg.mark_margin = ThreshReset;
    foreach (trk_hist[i]) trk_hist[i] = '0;
    trk_locked = 1'b0;
    trk_count = '0;
  endfunction

  // middle width at least threshold above both neighbours, compared at 9 bits
  function automatic logic index_mark();
    logic [8:0] mid, lo, hi;
    mid = {1'b0, trk_hist[1]};
    lo = {1'b0, trk_hist[0]} + {1'b0, trk_cfg.mark_margin};
    hi = {1'b0, trk_hist[2]} + {1'b0, trk_cfg.mark_margin};
    return (mid >= lo) && (mid >= hi);
  endfunction

  function automatic result_t track_pulse(input width_t w);
    result_t r;
    logic    mark;
    if (w != '0) begin
      trk_hist[0] = trk_hist[1];
      trk_hist[1] = trk_hist[2];
      trk_hist[2] = w;
      mark = index_mark();
      if (!trk_locked) begin
        if (mark) begin
          trk_locked = 1'b1;
          trk_count = count_t'(1);
          n_lock++;
        end
      end else begin
        if (trk_count == '1) n_wrap++;
        trk_count = trk_count + 1'b1;
        if (trk_count > trk_cfg.pulses_per_rotation) begin
          if (mark) begin
            trk_count = '0;
            n_rezero++;
          end else begin
            trk_locked = 1'b0;
            n_late++;
          end
        end else if (mark) begin
          trk_locked = 1'b0;
          n_early++;
        end
      end
    end
    r.position = trk_count;
    r.locked = trk_locked;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(15);
    if (r < 11) return $urandom_range(0, 2);
    if (r < 15) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic width_t near(input width_t base, input int jit);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 1) v = 1;
    if (v > 255) v = 255;
    return width_t'(v);
  endfunction

  task automatic send_width(input width_t w);
    int gap;
    position_q.push_back(track_pulse(w));
    if (w == '0) n_timeouts++;
    else n_pulses++;
    in_valid <= 1'b1;
    pulse_width <= w;
    do @(posedge clk); while (!in_ready);
    gap = tx_gaps ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (position_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PPR:    trk_cfg.pulses_per_rotation = d;
      REG_THRESH: trk_cfg.mark_margin = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [CfgDataBits-1:0] ppr,
                           input logic [CfgDataBits-1:0] thr);
    drain();
    write_reg(REG_PPR, ppr);
    write_reg(REG_THRESH, thr);
  endtask

  // len pulses near base, the one at peak_at raised clear of the threshold
  task automatic send_rotation(input int len, input int peak_at,
                               input width_t base, input int jit);
    int     top;
    width_t peak;
    top = int'(base) + jit + int'(trk_cfg.mark_margin) + int'($urandom_range(0, 20));
    peak = (top > 255) ? 8'hFF : width_t'(top);
    for (int k = 1; k <= len; k++) begin
      if ($urandom_range(19) == 0) send_width('0);
      send_width((k == peak_at) ? peak : near(base, jit));
    end
  endtask

  // lock lands on count 1, so the first rotation after it is one pulse short
  task automatic acquire(input width_t base, input int jit);
    int ppr;
    ppr = trk_cfg.pulses_per_rotation;
    send_rotation(3, 2, base, jit);
    if (trk_locked && ppr >= 2) send_rotation(ppr, ppr - 1, base, jit);
  endtask

  task automatic spin_rotations(input int nrot, input int break_pct);
    width_t base;
    int     jit;
    int     ppr;
    ppr = trk_cfg.pulses_per_rotation;
    base = width_t'($urandom_range(1, 120));
    jit = $urandom_range(0, 6);
    acquire(base, jit);
    for (int r = 0; r < nrot; r++) begin
      int len;
      int at;
      len = ppr + 1;
      at = ppr;
      if ($urandom_range(99) < break_pct) begin
        case ($urandom_range(3))
          0: at = ppr - 1;
          1: begin
            len = ppr + 2;
            at = ppr + 1;
          end
          2: at = 0;
          default: begin
            len = $urandom_range(1, ppr + 3);
            at = $urandom_range(1, len);
          end
        endcase
      end
      send_rotation(len, at, base, jit);
      if (!trk_locked) acquire(base, jit);
    end
  endtask

  task automatic test_directed();
    width_t seq [] = '{8'd10, 8'd40, 8'd10, 8'd10, 8'd50, 8'd10, 8'd0, 8'd10,
                       8'd60, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd0};
    // reset registers: timeout, extremes, then a sharp mark from the cleared history
    send_width('0);
    send_width(8'hFF);
    send_width(8'h01);
    send_width('0);
    // short rotation: on-time mark, early mark, relock, late unlock, frozen count
    configure(8'd3, 8'd16);
    foreach (seq[i]) send_width(seq[i]);
  endtask

  task automatic test_spare_indexes();
    drain();
    write_reg(RegSpareA, cfg_data_t'($urandom_range(0, 255)));
    write_reg(RegSpareB, cfg_data_t'($urandom_range(0, 255)));
    spin_rotations(3, 0);
  endtask

  task automatic test_zero_rotation();
    width_t w;
    // zero threshold with flat widths marks an index on every pulse once the history holds them
    configure(8'd0, 8'd0);
    w = width_t'($urandom_range(1, 255));
    repeat (12) send_width(w);
    configure(8'd0, cfg_data_t'($urandom_range(1, 30)));
    spin_rotations(4, 30);
  endtask

  task automatic test_count_wrap();
    width_t base;
    configure(8'hFF, 8'd20);
    base = width_t'($urandom_range(1, 100));
    send_rotation(3, 2, base, 2);
    // run the count past 255 with no mark, then mark early on the small value
    send_rotation(260, 0, base, 2);
    send_rotation(4, 2, base, 2);
  endtask

  task automatic test_random_rotations();
    int start;
    int ppr;
    int thr;
    start = n_pulses;
    while (n_pulses - start < RandomPulses) begin
      case ($urandom_range(9))
        0: ppr = $urandom_range(0, 1);
        1: ppr = $urandom_range(13, 40);
        default: ppr = $urandom_range(2, 12);
      endcase
      case ($urandom_range(9))
        0: thr = 0;
        1: thr = $urandom_range(61, 255);
        default: thr = $urandom_range(4, 60);
      endcase
      configure(cfg_data_t'(ppr), cfg_data_t'(thr));
      tx_gaps = ($urandom_range(3) != 0);
      rx_stalls = ($urandom_range(3) != 0);
      spin_rotations($urandom_range(2, 6), 20);
      if ($urandom_range(2) == 0) begin
        drain();
        spin_rotations($urandom_range(1, 3), 20);
      end
    end
  endtask

  task automatic test_noise_widths();
    configure(cfg_data_t'($urandom_range(0, 255)), cfg_data_t'($urandom_range(0, 255)));
    repeat (60) send_width(($urandom_range(9) == 0) ? 8'h00 : width_t'($urandom_range(1, 255)));
    configure(8'hFF, 8'hFF);
    repeat (20) send_width(width_t'($urandom_range(0, 255)));
    configure(8'h00, 8'h00);
    repeat (20) send_width(width_t'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= rx_stalls ? ($urandom_range(2) != 0) : 1'b1;
      ready_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin : check_word
      result_t want;
      n_results++;
      if (position_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MaxReports)
          $display("result %0d with nothing outstanding: position %0d locked %0b",
                   n_results, position, locked);
      end else begin
        want = position_q.pop_front();
        if (position !== want.position || locked !== want.locked) begin
          n_mismatch++;
          if (n_mismatch <= MaxReports)
            $display("result %0d: position %0d locked %0b, expected position %0d locked %0b",
                     n_results, position, locked, want.position, want.locked);
        end
      end
    end
  end

  initial begin
    reset_tracker();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    ready_hold = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    test_spare_indexes();
    test_zero_rotation();
    test_random_rotations();
    test_noise_widths();
    test_count_wrap();
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d pulses and %0d timeouts, checked %0d results, %0d mismatches",
             n_pulses, n_timeouts, n_results, n_mismatch);
    $display("locks %0d, on-time marks %0d, early %0d, late %0d, count wraps %0d",
             n_lock, n_rezero, n_early, n_late, n_wrap);
    if (n_mismatch == 0 && position_q.size() == 0) begin
      $display("[rotor_index_position_tracker] OK");
    end else begin
      $display("[rotor_index_position_tracker] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[rotor_index_position_tracker] ERROR");
    $finish;
  end

endmodule
